### rtl/core/rgbhsv_pkg.sv
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// shared types, constants and helpers of the rgb to hsv converter
// ----------------------------------------------------------------------------
package rgbhsv_pkg;

  // hue geometry, degrees
  localparam int unsigned HUE_SECTOR = 60;
  localparam int unsigned HUE_GREEN  = 120;
  localparam int unsigned HUE_BLUE   = 240;
  localparam int unsigned HUE_FULL   = 360;
  localparam int unsigned CHAN_MAX   = 255;

  // divider: 16-bit dividend, 8-bit divisor, 8-bit quotient
  localparam int unsigned QUOT_W         = 8;
  localparam int unsigned DIV_STEPS      = 2;
  localparam int unsigned DIV_STAGES     = QUOT_W / DIV_STEPS;

  // pipeline stage positions
  localparam int unsigned ST_PIX   = 0;
  localparam int unsigned ST_PRE   = 1;
  localparam int unsigned ST_INIT  = 2;
  localparam int unsigned ST_DIV0  = 3;
  localparam int unsigned ST_OUT   = ST_DIV0 + DIV_STAGES;
  localparam int unsigned ST_DEPTH = ST_OUT + 1;

  typedef enum logic [1:0] {
    BASE_RED,
    BASE_GREEN,
    BASE_BLUE
  } hue_base_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

  // per-pixel data that rides alongside the divider
  typedef struct packed {
    logic [7:0] mx;
    logic       gray;
    logic       neg;
    hue_base_e  base;
    logic [7:0] alpha;
  } side_t;

  typedef struct packed {
    side_t      side;
    logic [7:0] delta;
    logic [7:0] abs_diff;
  } pre_t;

  // restoring divider state
  typedef struct packed {
    logic [7:0] p;   // partial remainder
    logic [7:0] lo;  // dividend bits still to shift in
    logic [7:0] q;   // quotient so far
    logic [7:0] d;   // divisor
  } div_t;

  typedef struct packed {
    side_t side;
    div_t  hdiv;
    div_t  sdiv;
  } stage_t;

  function automatic logic [9:0] hue_base(hue_base_e b);
    logic [9:0] v;
    unique case (b)
      BASE_RED:   v = 10'd0;
      BASE_GREEN: v = 10'(HUE_GREEN);
      BASE_BLUE:  v = 10'(HUE_BLUE);
      default:    v = 10'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/rgbhsv_if.sv
// ----------------------------------------------------------------------------
// rgbhsv_pix_if / rgbhsv_hsv_if
// valid/ready channels for rgba pixels in and hsva words out
// ----------------------------------------------------------------------------
interface rgbhsv_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface rgbhsv_hsv_if;
  logic       valid;
  logic       ready;
  logic [8:0] hue;
  logic [7:0] saturation;
  logic [7:0] value;
  logic [7:0] alpha_out;

  modport source (output valid, hue, saturation, value, alpha_out, input ready);
  modport sink   (input valid, hue, saturation, value, alpha_out, output ready);
endinterface

### rtl/core/rgbhsv_div_step.sv
// ----------------------------------------------------------------------------
// rgbhsv_div_step
// restoring division, a fixed number of quotient bits per pass
// ----------------------------------------------------------------------------
module rgbhsv_div_step
  import rgbhsv_pkg::*;
(
  input  div_t a_i,
  output div_t y_o
);

  always_comb begin
    div_t       t;
    logic [8:0] trial;
    t = a_i;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial = {t.p, t.lo[7]};
      t.lo  = {t.lo[6:0], 1'b0};
      if (trial >= {1'b0, t.d}) begin
        t.p = 8'(trial - {1'b0, t.d});
        t.q = {t.q[6:0], 1'b1};
      end else begin
        t.p = trial[7:0];
        t.q = {t.q[6:0], 1'b0};
      end
    end
    y_o = t;
  end

endmodule

### rtl/core/rgb_to_hsv_convert_core.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_core
// pipelined rgba to hsva pixel converter
// ----------------------------------------------------------------------------
//
//  channel  dir  modport  word
//  -------  ---  -------  -----------------------------------------
//  pix_i    in   sink     red, green, blue, alpha (8 bits each)
//  hsv_o    out  source   hue (9), saturation (8), value (8), alpha_out (8)
//
//  one pixel per clock sustained while hsv_o.ready stays high
//  pipeline depth is set by the two dividers (hue and saturation), four stages of
//  two quotient bits each, plus input, min/max, setup and output stages
//  each stage has its own valid bit and holds while the one ahead is full,
//  so bubbles close up and a stall drops or repeats nothing
//  rst_ni clears only the valid bits
//
module rgb_to_hsv_convert_core
  import rgbhsv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  rgbhsv_pix_if.sink   pix_i,
  rgbhsv_hsv_if.source hsv_o
);

  // --------------------------------------------------------------------------
  // pipeline flow control
  // --------------------------------------------------------------------------
  logic [ST_DEPTH-1:0] vld_q;
  logic [ST_DEPTH:0]   rdy;

  // a stage may load when it is empty or the stage ahead is loading
  always_comb begin
    rdy[ST_DEPTH] = hsv_o.ready;
    for (int k = ST_DEPTH - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[ST_PIX]) begin
        vld_q[ST_PIX] <= pix_i.valid;
      end
      for (int k = 1; k < ST_DEPTH; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign pix_i.ready = rdy[ST_PIX];

  // --------------------------------------------------------------------------
  // stage 0: input register
  // --------------------------------------------------------------------------
  pix_t pix_q;

  always_ff @(posedge clk_i) begin
    if (rdy[ST_PIX]) begin
      pix_q <= '{red: pix_i.red, green: pix_i.green, blue: pix_i.blue, alpha: pix_i.alpha};
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: max, min, branch pick and signed channel difference
  // --------------------------------------------------------------------------
  pre_t pre_d, pre_q;

  always_comb begin
    logic [7:0] mx, mn;
    logic [8:0] diff;
    mx = pix_q.red;
    mn = pix_q.red;
    if (pix_q.green > mx) mx = pix_q.green;
    if (pix_q.blue  > mx) mx = pix_q.blue;
    if (pix_q.green < mn) mn = pix_q.green;
    if (pix_q.blue  < mn) mn = pix_q.blue;

    // red wins every tie, green wins ties with blue
    priority if (pix_q.red == mx) begin
      pre_d.side.base = BASE_RED;
      diff = {1'b0, pix_q.green} - {1'b0, pix_q.blue};
    end else if (pix_q.green == mx) begin
      pre_d.side.base = BASE_GREEN;
      diff = {1'b0, pix_q.blue} - {1'b0, pix_q.red};
    end else begin
      pre_d.side.base = BASE_BLUE;
      diff = {1'b0, pix_q.red} - {1'b0, pix_q.green};
    end

    pre_d.side.mx    = mx;
    pre_d.side.alpha = pix_q.alpha;
    pre_d.delta      = mx - mn;
    pre_d.side.gray  = (mx == mn);
    pre_d.side.neg   = diff[8];
    pre_d.abs_diff   = diff[8] ? 8'(-diff) : diff[7:0];
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_PRE]) begin
      pre_q <= pre_d;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: dividends and divider setup
  // hue: 60 * |diff| / delta, saturation: delta * 255 / max
  // both quotients fit 8 bits since |diff| <= delta <= max
  // --------------------------------------------------------------------------
  stage_t init_d, init_q;

  always_comb begin
    logic [15:0] hnum, snum;
    hnum = 16'(16'(pre_q.abs_diff) * 16'(HUE_SECTOR));
    snum = 16'(16'(pre_q.delta) * 16'(CHAN_MAX));

    init_d.side    = pre_q.side;
    init_d.hdiv.p  = hnum[15:8];
    init_d.hdiv.lo = hnum[7:0];
    init_d.hdiv.q  = '0;
    init_d.hdiv.d  = pre_q.delta;
    init_d.sdiv.p  = snum[15:8];
    init_d.sdiv.lo = snum[7:0];
    init_d.sdiv.q  = '0;
    init_d.sdiv.d  = pre_q.side.mx;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_INIT]) begin
      init_q <= init_d;
    end
  end

  // --------------------------------------------------------------------------
  // divider stages
  // --------------------------------------------------------------------------
  stage_t div_in  [DIV_STAGES];
  stage_t div_out [DIV_STAGES];
  stage_t div_q   [DIV_STAGES];

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    if (j == 0) begin : g_first
      assign div_in[j] = init_q;
    end else begin : g_next
      assign div_in[j] = div_q[j-1];
    end

    assign div_out[j].side = div_in[j].side;

    rgbhsv_div_step u_hue_step (
      .a_i (div_in[j].hdiv),
      .y_o (div_out[j].hdiv)
    );

    rgbhsv_div_step u_sat_step (
      .a_i (div_in[j].sdiv),
      .y_o (div_out[j].sdiv)
    );

    always_ff @(posedge clk_i) begin
      if (rdy[ST_DIV0 + j]) begin
        div_q[j] <= div_out[j];
      end
    end
  end

  // --------------------------------------------------------------------------
  // output stage: ceiling, sector offset, wrap, black and gray cases
  // --------------------------------------------------------------------------
  stage_t     last;
  logic [8:0] hue_d, hue_q;
  logic [7:0] sat_d, sat_q;
  logic [7:0] val_q, alpha_q;

  assign last = div_q[DIV_STAGES-1];

  always_comb begin
    logic [9:0] mag, h;
    logic       inexact;
    mag     = {2'b00, last.hdiv.q};
    inexact = (last.hdiv.p != 8'd0);
    // ceiling rounds a positive quotient up, a negative one toward zero
    if (last.side.neg) begin
      h = hue_base(last.side.base) - mag;
    end else begin
      h = hue_base(last.side.base) + mag + {9'd0, inexact};
    end
    if (h[9]) begin
      h = h + 10'(HUE_FULL);
    end
    hue_d = last.side.gray ? 9'd0 : h[8:0];
    sat_d = (last.side.mx == 8'd0) ? 8'd0 : last.sdiv.q;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_OUT]) begin
      hue_q   <= hue_d;
      sat_q   <= sat_d;
      val_q   <= last.side.mx;
      alpha_q <= last.side.alpha;
    end
  end

  assign hsv_o.valid      = vld_q[ST_OUT];
  assign hsv_o.hue        = hue_q;
  assign hsv_o.saturation = sat_q;
  assign hsv_o.value      = val_q;
  assign hsv_o.alpha_out  = alpha_q;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------

  // hue always wrapped into one turn
  a_hue_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hsv_o.valid |-> (hsv_o.hue < 9'(HUE_FULL)))
    else $error("hue out of range");

  // black pixel gives zero hue and zero saturation
  a_black : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hsv_o.valid && hsv_o.value == 8'd0) |-> (hsv_o.hue == 9'd0 && hsv_o.saturation == 8'd0))
    else $error("black pixel with nonzero hue or saturation");

  // divider setup keeps the saturation partial remainder below its divisor, the hue one at most its divisor
  a_div_setup : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_INIT] && init_q.sdiv.d != 8'd0) |->
      (init_q.sdiv.p < init_q.sdiv.d && init_q.hdiv.p <= init_q.hdiv.d))
    else $error("divider setup overflows quotient width");

  // a full last divider stage is not dropped while the output stalls
  a_div_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_OUT-1] && !rdy[ST_OUT]) |=> vld_q[ST_OUT-1])
    else $error("word lost in divider pipeline");

endmodule
